FILE: rtl/ccv_pkg.sv
// shared types and constants of the 2-d correlate / convolve block
package ccv_pkg;

  localparam int DATA_W     = 16;
  localparam int POS_W      = 10;
  localparam int COEF_IDX_W = 4;
  localparam int CFG_W      = 11;
  localparam int FRAC_W     = 12;

  localparam int KERNEL_SIZE_DEF = 3;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    ACT_COEF  = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_DRAIN = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef struct packed {
    action_e                  action;
    logic [COEF_IDX_W-1:0]    coef_index;
    logic signed [DATA_W-1:0] coef_value;
    logic signed [DATA_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         out_row;
    logic [POS_W-1:0]         out_col;
    logic                     frame_last;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic             flip;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } meta_t;

endpackage

FILE: rtl/ccv_if.sv
// valid / ready channels for input items and result items
interface ccv_in_if;
  logic               valid;
  logic               ready;
  ccv_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ccv_out_if;
  logic               valid;
  logic               ready;
  ccv_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/image_correlate_convolve_2d.sv
// top level: streaming 2-d correlation / convolution with replicated border
//
// in_i carries beats of four kinds: coefficient loads, pixels in raster order,
// drain ticks and no-op beats. out_o carries one filtered pixel per result
// beat, with row, column, last-of-frame and saturation flags, in raster order.
// Configuration (mode, width, height) is written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must write it only while the block is idle, and the
// block itself leaves this unchecked. The input is held off after each write
// until a hold counter runs out. A result passes the line memory read and
// the chain of multiply-accumulate cells; one pixel or drain beat is taken
// every cycle while queue credit is free and no configuration hold runs.
// A coefficient beat waits until earlier results have left the multiply chain.
// A stalled receiver fills the result queue; in_i.ready drops once results
// in flight and queued reach its depth, so nothing is lost.
// Reset clears the coefficients, positions and counters and sets mode to
// correlation and the frame to 1024 x 1024; line memories are not cleared
// and must be written before they are read.
module image_correlate_convolve_2d #(
  parameter int KERNEL_SIZE = ccv_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = ccv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = ccv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ccv_in_if.sink                     in_i,
  ccv_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ccv_pkg::CFG_W-1:0]  cfg_wdata_i
);

  localparam int ORIGIN     = KERNEL_SIZE / 2;
  localparam int TAPS       = KERNEL_SIZE * KERNEL_SIZE;
  localparam int RING       = 3 * ORIGIN + 2;
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int GW         = $clog2(RING);
  localparam int EW         = CW + 1;
  localparam int EH         = RW + 1;
  localparam int LAG_W      = $clog2(ORIGIN * (MAX_WIDTH + 1) + 2);
  localparam int SW         = 2 * ccv_pkg::DATA_W + $clog2(TAPS) + 1;
  localparam int FIFO_DEPTH = 2 ** $clog2(TAPS + 6);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int RS         = RW + GW;
  localparam int RM         = (2 ** RS) / RING;
  localparam int H_DEF      = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
  localparam int HQ_RST     = (H_DEF - 1) / RING;
  localparam int HR_RST     = (H_DEF - 1) % RING;

  localparam logic signed [SW-1:0] SAT_MAX = SW'(32767);
  localparam logic signed [SW-1:0] SAT_MIN = -SW'(32768);

  // configuration
  logic                      mode_q;
  logic [ccv_pkg::CFG_W-1:0] width_q, height_q;
  logic [1:0]                hold_q;
  logic [EW-1:0]             eff_w;
  logic [EH-1:0]             eff_h;
  logic [CW-1:0]             wm1;
  logic [RW-1:0]             hm1;
  logic [RW-1:0]             hq_q;
  logic [GW:0]               hrem;
  logic [GW-1:0]             hm1_ring_q;

  // positions and bookkeeping
  logic [CW-1:0]    in_col_q, emit_col_q, in_col_d, emit_col_d, ic;
  logic [RW-1:0]    in_row_q, emit_row_q, in_row_d, emit_row_d, ir;
  logic [GW-1:0]    in_ring_q, emit_ring_q, in_ring_d, emit_ring_d, ir_ring;
  logic [LAG_W-1:0] owed_q, owed_d, lag, owed_base;
  logic             tail_q, tail_d;
  logic [EW-1:0]    col_nx, ec_nx;
  logic [EH-1:0]    row_nx, er_nx;
  logic             col_wrap, row_wrap, ecw, erw;
  logic             in_acc, is_pix, is_drain, is_coef, last_in, emit_go;
  logic             chain_busy;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] fifo_level;

  // window addressing
  logic [GW-1:0]    row_ring [KERNEL_SIZE];
  logic [CW-1:0]    col_addr [KERNEL_SIZE];
  logic [GW-1:0]    s1_ring_q [KERNEL_SIZE];
  logic [CW-1:0]    s1_col_q [KERNEL_SIZE];
  ccv_pkg::meta_t   s1_meta_q, meta_e;
  ccv_pkg::meta_t   meta_q [TAPS+2];
  logic             last_e;
  int               rv, cv;

  // datapath
  logic signed [ccv_pkg::DATA_W-1:0] tap [TAPS];
  logic signed [SW-1:0]              chain_sum [TAPS+1];
  logic signed [SW-1:0]              shifted;
  ccv_pkg::out_item_t                push_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= ccv_pkg::CFG_W'(1024);
      height_q <= ccv_pkg::CFG_W'(1024);
      hold_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        hold_q <= 2'd3;
        case (cfg_idx_i)
          ccv_pkg::CFG_MODE:   mode_q   <= cfg_wdata_i[0];
          ccv_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
          ccv_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end else if (hold_q != '0) begin
        hold_q <= hold_q - 2'd1;
      end
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = EW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = EH'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(height_q);
    end
  end

  assign wm1  = CW'(eff_w - EW'(1));
  assign hm1  = RW'(eff_h - EH'(1));
  // last row modulo ring depth by reciprocal
  assign hrem = (GW+1)'(32'(hm1) - 32'(hq_q) * RING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hq_q       <= RW'(HQ_RST);
      hm1_ring_q <= GW'(HR_RST);
    end else begin
      hq_q       <= RW'((32'(hm1) * RM) >> RS);
      hm1_ring_q <= (32'(hrem) >= RING) ? GW'(32'(hrem) - RING) : GW'(hrem);
    end
  end

  // results still reading coefficients in the cell chain
  always_comb begin
    chain_busy = s1_meta_q.valid;
    for (int k = 0; k < TAPS - 1; k++) begin
      chain_busy = chain_busy || meta_q[k].valid;
    end
  end

  assign in_i.ready = (32'(cnt_q) < FIFO_DEPTH) && (hold_q == '0)
                      && !(is_coef && chain_busy);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_pix     = (in_i.data.action == ccv_pkg::ACT_PIXEL);
  assign is_drain   = (in_i.data.action == ccv_pkg::ACT_DRAIN);
  assign is_coef    = (in_i.data.action == ccv_pkg::ACT_COEF);

  always_comb begin
    if ({1'b0, in_col_q} >= eff_w) begin
      ic = wm1;
    end else begin
      ic = in_col_q;
    end
    if ({1'b0, in_row_q} >= eff_h) begin
      ir      = hm1;
      ir_ring = hm1_ring_q;
    end else begin
      ir      = in_row_q;
      ir_ring = in_ring_q;
    end
  end

  assign lag       = LAG_W'(ORIGIN * (32'(eff_w) + 1));
  assign last_in   = (ir == hm1) && (ic == wm1);
  assign owed_base = (is_pix && (owed_q <= lag)) ? owed_q + LAG_W'(1) : owed_q;
  assign emit_go   = in_acc && ((is_pix && (tail_q || (owed_base > lag)))
                                || (is_drain && tail_q));

  // input position
  assign col_nx   = {1'b0, ic} + EW'(1);
  assign col_wrap = (col_nx >= eff_w);
  assign row_nx   = {1'b0, ir} + EH'(1);
  assign row_wrap = (row_nx >= eff_h);

  always_comb begin
    in_col_d  = ic;
    in_row_d  = ir;
    in_ring_d = ir_ring;
    if (col_wrap) begin
      in_col_d = '0;
      if (row_wrap) begin
        in_row_d  = '0;
        in_ring_d = '0;
      end else begin
        in_row_d  = row_nx[RW-1:0];
        in_ring_d = (ir_ring == GW'(RING - 1)) ? '0 : ir_ring + GW'(1);
      end
    end else begin
      in_col_d = col_nx[CW-1:0];
    end
  end

  // emit position
  assign ec_nx = {1'b0, emit_col_q} + EW'(1);
  assign ecw   = (ec_nx >= eff_w);
  assign er_nx = {1'b0, emit_row_q} + EH'(1);
  assign erw   = (er_nx >= eff_h);

  always_comb begin
    emit_col_d  = emit_col_q;
    emit_row_d  = emit_row_q;
    emit_ring_d = emit_ring_q;
    if (ecw) begin
      emit_col_d = '0;
      if (erw) begin
        emit_row_d  = '0;
        emit_ring_d = '0;
      end else begin
        emit_row_d  = er_nx[RW-1:0];
        emit_ring_d = (emit_ring_q == GW'(RING - 1)) ? '0 : emit_ring_q + GW'(1);
      end
    end else begin
      emit_col_d = ec_nx[CW-1:0];
    end
  end

  always_comb begin
    owed_d = owed_base;
    if (emit_go && (owed_base != '0)) begin
      owed_d = owed_base - LAG_W'(1);
    end
    tail_d = tail_q;
    if (emit_go && ecw && erw) begin
      tail_d = 1'b0;
    end
    if (is_pix && last_in && (owed_d != '0)) begin
      tail_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_ring_q   <= '0;
      emit_col_q  <= '0;
      emit_row_q  <= '0;
      emit_ring_q <= '0;
      owed_q      <= '0;
      tail_q      <= 1'b0;
    end else if (in_acc) begin
      owed_q <= owed_d;
      tail_q <= tail_d;
      if (is_pix) begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        in_ring_q <= in_ring_d;
      end
      if (emit_go) begin
        emit_col_q  <= emit_col_d;
        emit_row_q  <= emit_row_d;
        emit_ring_q <= emit_ring_d;
      end
    end
  end

  // window rows and columns with the border replicated
  always_comb begin
    rv = 0;
    cv = 0;
    for (int a = 0; a < KERNEL_SIZE; a++) begin
      rv = int'(emit_ring_q) + a - ORIGIN;
      if (rv < 0) begin
        rv = rv + RING;
      end else if (rv >= RING) begin
        rv = rv - RING;
      end
      if (int'(emit_row_q) + a < ORIGIN) begin
        row_ring[a] = '0;
      end else if (int'(emit_row_q) + a > int'(hm1) + ORIGIN) begin
        row_ring[a] = hm1_ring_q;
      end else begin
        row_ring[a] = GW'(rv);
      end
    end
    for (int b = 0; b < KERNEL_SIZE; b++) begin
      cv = int'(emit_col_q) + b;
      if (cv < ORIGIN) begin
        col_addr[b] = '0;
      end else if (cv - ORIGIN > int'(wm1)) begin
        col_addr[b] = wm1;
      end else begin
        col_addr[b] = CW'(cv - ORIGIN);
      end
    end
  end

  assign last_e = (emit_row_q >= hm1) && (emit_col_q >= wm1);

  always_comb begin
    meta_e       = '0;
    meta_e.valid = emit_go;
    meta_e.flip  = mode_q;
    meta_e.row   = ccv_pkg::POS_W'(emit_row_q);
    meta_e.col   = ccv_pkg::POS_W'(emit_col_q);
    meta_e.last  = last_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_meta_q <= '0;
      meta_q    <= '{default: '0};
    end else begin
      s1_meta_q <= meta_e;
      meta_q[0] <= s1_meta_q;
      for (int k = 1; k < TAPS + 2; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ring_q <= row_ring;
    s1_col_q  <= col_addr;
  end

  ccv_linebuf #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH),
    .RING        (RING),
    .CW          (CW),
    .GW          (GW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && is_pix),
    .wr_ring_i (ir_ring),
    .wr_col_i  (ic),
    .wr_data_i (in_i.data.pixel),
    .rd_ring_i (s1_ring_q),
    .rd_col_i  (s1_col_q),
    .tap_o     (tap)
  );

  assign chain_sum[0] = '0;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    ccv_cell #(
      .IDX   (i),
      .SUM_W (SW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .coef_we_i   (in_acc && is_coef),
      .coef_idx_i  (in_i.data.coef_index),
      .coef_data_i (in_i.data.coef_value),
      .pix_i       (meta_q[0].flip ? tap[TAPS-1-i] : tap[i]),
      .sum_i       (chain_sum[i]),
      .sum_o       (chain_sum[i+1])
    );
  end

  assign shifted = chain_sum[TAPS] >>> ccv_pkg::FRAC_W;

  always_comb begin
    push_item            = '0;
    push_item.out_row    = meta_q[TAPS+1].row;
    push_item.out_col    = meta_q[TAPS+1].col;
    push_item.frame_last = meta_q[TAPS+1].last;
    if (shifted > SAT_MAX) begin
      push_item.value     = ccv_pkg::DATA_W'(SAT_MAX);
      push_item.saturated = 1'b1;
    end else if (shifted < SAT_MIN) begin
      push_item.value     = ccv_pkg::DATA_W'(SAT_MIN);
      push_item.saturated = 1'b1;
    end else begin
      push_item.value     = ccv_pkg::DATA_W'(shifted);
      push_item.saturated = 1'b0;
    end
  end

  ccv_fifo #(
    .DEPTH (FIFO_DEPTH),
    .LW    (CNT_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (meta_q[TAPS+1].valid),
    .push_data_i (push_item),
    .level_o     (fifo_level),
    .out_o       (out_o)
  );

  // results in flight or queued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(emit_go) - CNT_W'(out_o.valid && out_o.ready);
    end
  end

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= FIFO_DEPTH)
    else $error("result credit count above queue depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_q[TAPS+1].valid |-> (32'(fifo_level) < FIFO_DEPTH))
    else $error("result pushed into a full queue");

  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_drain && !tail_q) |=> !s1_meta_q.valid)
    else $error("drain beat without frame tail produced a result");

  a_queue_within_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_level <= cnt_q)
    else $error("queue holds more results than were issued");

endmodule

FILE: rtl/ccv_linebuf.sv
// ring of line memories, one copy per window column, with row select of the taps
module ccv_linebuf #(
  parameter int KERNEL_SIZE = ccv_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = ccv_pkg::MAX_WIDTH_DEF,
  parameter int RING        = 3 * (KERNEL_SIZE / 2) + 2,
  parameter int CW          = $clog2(MAX_WIDTH),
  parameter int GW          = $clog2(RING)
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [GW-1:0]                     wr_ring_i,
  input  logic [CW-1:0]                     wr_col_i,
  input  logic signed [ccv_pkg::DATA_W-1:0] wr_data_i,
  input  logic [GW-1:0]                     rd_ring_i [KERNEL_SIZE],
  input  logic [CW-1:0]                     rd_col_i [KERNEL_SIZE],
  output logic signed [ccv_pkg::DATA_W-1:0] tap_o [KERNEL_SIZE*KERNEL_SIZE]
);

  logic signed [ccv_pkg::DATA_W-1:0] rd_q [RING][KERNEL_SIZE];
  logic [GW-1:0]                     ring_q [KERNEL_SIZE];

  for (genvar g = 0; g < RING; g++) begin : g_row
    for (genvar b = 0; b < KERNEL_SIZE; b++) begin : g_copy
      logic signed [ccv_pkg::DATA_W-1:0] mem [MAX_WIDTH];
      always_ff @(posedge clk_i) begin
        if (wr_en_i && (wr_ring_i == GW'(g))) begin
          mem[wr_col_i] <= wr_data_i;
        end
        rd_q[g][b] <= mem[rd_col_i[b]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ring_q <= rd_ring_i;
  end

  always_comb begin
    for (int a = 0; a < KERNEL_SIZE; a++) begin
      for (int b = 0; b < KERNEL_SIZE; b++) begin
        tap_o[a*KERNEL_SIZE+b] = rd_q[ring_q[a]][b];
      end
    end
  end

endmodule

FILE: rtl/ccv_cell.sv
// one multiply-accumulate cell of the systolic sum chain, holding one coefficient
module ccv_cell #(
  parameter int IDX   = 0,
  parameter int SUM_W = 2 * ccv_pkg::DATA_W + 5
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  coef_we_i,
  input  logic [ccv_pkg::COEF_IDX_W-1:0]        coef_idx_i,
  input  logic signed [ccv_pkg::DATA_W-1:0]     coef_data_i,
  input  logic signed [ccv_pkg::DATA_W-1:0]     pix_i,
  input  logic signed [SUM_W-1:0]               sum_i,
  output logic signed [SUM_W-1:0]               sum_o
);

  logic signed [ccv_pkg::DATA_W-1:0]   coef_q;
  logic signed [ccv_pkg::DATA_W-1:0]   pix_dly;
  logic signed [2*ccv_pkg::DATA_W-1:0] prod_q;
  logic signed [SUM_W-1:0]             sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (coef_we_i && (32'(coef_idx_i) == IDX)) begin
      coef_q <= coef_data_i;
    end
  end

  // skew the pixel so it meets the partial sum of the same beat
  if (IDX == 0) begin : g_nodly
    assign pix_dly = pix_i;
  end else begin : g_dly
    logic signed [ccv_pkg::DATA_W-1:0] line_q [IDX];
    always_ff @(posedge clk_i) begin
      line_q[0] <= pix_i;
      for (int k = 1; k < IDX; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
    assign pix_dly = line_q[IDX-1];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_q * pix_dly;
    sum_q  <= sum_i + SUM_W'(prod_q);
  end

  assign sum_o = sum_q;

endmodule

FILE: rtl/ccv_fifo.sv
// result queue in front of the output channel
module ccv_fifo #(
  parameter int DEPTH = 16,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ccv_pkg::out_item_t push_data_i,
  output logic [LW-1:0]      level_o,
  ccv_out_if.source          out_o
);

  localparam int PW = $clog2(DEPTH);

  ccv_pkg::out_item_t mem [DEPTH];
  logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [LW-1:0]      level_q;
  logic               pop;

  assign pop        = out_o.valid && out_o.ready;
  assign out_o.valid = (level_q != '0);
  assign out_o.data  = mem[rd_ptr_q];
  assign level_o     = level_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      level_q <= level_q + LW'(push_i) - LW'(pop);
    end
  end

endmodule
